>>> design/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants for the packet header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package phd_pkg;

   // header layout
   localparam int unsigned HdrBytes = 8;
   localparam int unsigned HdrIdxW  = $clog2(HdrBytes);

   localparam logic [HdrIdxW-1:0] HdrFlags   = HdrIdxW'(0);
   localparam logic [HdrIdxW-1:0] HdrSessHi  = HdrIdxW'(2);
   localparam logic [HdrIdxW-1:0] HdrSessLo  = HdrIdxW'(3);
   localparam logic [HdrIdxW-1:0] HdrLenHi   = HdrIdxW'(6);
   localparam logic [HdrIdxW-1:0] HdrLenLo   = HdrIdxW'(HdrBytes - 1);

   // flag bit positions
   localparam int unsigned FlagPush  = 0;
   localparam int unsigned FlagAbort = 1;
   localparam int unsigned FlagClose = 2;
   localparam int unsigned FlagOpen  = 3;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_ABORT = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_OPEN  = 2'd3
   } kind_type;

   // one result beat
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        push_bit;
      kind_type    control_kind;
      logic [15:0] session_id;
      logic        last_of_packet;
   } rsp_type;

   // control kind from flags, abort over close over open
   function automatic kind_type kind_of(input logic [3:0] flags);
      kind_type k;
      if (flags[FlagAbort]) begin
         k = KIND_ABORT;
      end else if (flags[FlagClose]) begin
         k = KIND_CLOSE;
      end else if (flags[FlagOpen]) begin
         k = KIND_OPEN;
      end else begin
         k = KIND_NONE;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

>>> design/packet_header_deframer.sv
// ----------------------------------------------------------------------------
// packet_header_deframer
// Splits a byte stream into packets with an 8-byte header and emits one
// result beat per payload byte, or one marker beat for an empty packet.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one stream byte per beat (req_rx_byte), valid/ready.
//   rsp_ channel: one result beat per payload byte carrying the payload
//     byte, push bit, control kind, session id and last-of-packet marker.
//     A zero-length packet yields a single beat with payload_valid low.
//   Header bytes produce no beat, except the final header byte of an
//     empty packet.
//   Each accepted byte's result is registered before it appears on rsp_.
//   Throughput: one byte per cycle while req_ready is high; the header
//     registers and 16-bit remaining-byte counter update per accepted byte.
//   Stall: results go to an output register backed by a one-entry skid
//     register, so a byte is still accepted in the cycle the receiver
//     first stalls; req_ready drops only once the skid register is full.
//   Reset: synchronous, active high; clears the header position, flags,
//     session, length and payload state and empties both result registers.
//     A partially received packet is simply held until more bytes arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_deframer
   import phd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_valid,
   output logic             rsp_push_bit,
   output logic [1:0]       rsp_control_kind,
   output logic [15:0]      rsp_session_id,
   output logic             rsp_last_of_packet
);

   // deframing state
   logic [HdrIdxW-1:0] hdr_idx_ff,   hdr_idx_in;
   logic [3:0]         flags_ff,     flags_in;
   logic [15:0]        session_ff,   session_in;
   logic [7:0]         len_hi_ff,    len_hi_in;
   logic [15:0]        remain_ff,    remain_in;
   logic               in_payload_ff, in_payload_in;

   // result registers
   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic    accept;
   logic    pop;
   logic    new_valid;
   rsp_type new_rsp;
   logic [15:0] remain_dec;
   logic [15:0] len_full;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign pop       = out_valid_ff & rsp_ready;

   // per-byte deframing
   always_comb begin
      hdr_idx_in    = hdr_idx_ff;
      flags_in      = flags_ff;
      session_in    = session_ff;
      len_hi_in     = len_hi_ff;
      remain_in     = remain_ff;
      in_payload_in = in_payload_ff;
      new_valid     = 1'b0;
      remain_dec    = remain_ff - 16'd1;
      len_full      = {len_hi_ff, req_rx_byte};

      new_rsp.payload_byte   = req_rx_byte;
      new_rsp.payload_valid  = 1'b1;
      new_rsp.push_bit       = flags_ff[FlagPush];
      new_rsp.control_kind   = kind_of(flags_ff);
      new_rsp.session_id     = session_ff;
      new_rsp.last_of_packet = (remain_dec == 16'd0);

      if (accept) begin
         if (in_payload_ff) begin
            // payload byte
            remain_in = remain_dec;
            new_valid = 1'b1;
            if (remain_dec == 16'd0) begin
               in_payload_in = 1'b0;
            end
         end else begin
            // header byte
            case (hdr_idx_ff)
               HdrFlags:  flags_in = req_rx_byte[3:0];
               HdrSessHi: session_in = {req_rx_byte, session_ff[7:0]};
               HdrSessLo: session_in = {session_ff[15:8], req_rx_byte};
               HdrLenHi:  len_hi_in = req_rx_byte;
               default:   ;
            endcase
            if (hdr_idx_ff == HdrLenLo) begin
               hdr_idx_in = '0;
               if (len_full == 16'd0) begin
                  // empty packet marker
                  new_valid              = 1'b1;
                  new_rsp.payload_byte   = 8'd0;
                  new_rsp.payload_valid  = 1'b0;
                  new_rsp.last_of_packet = 1'b1;
               end else begin
                  remain_in     = len_full;
                  in_payload_in = 1'b1;
               end
            end else begin
               hdr_idx_in = hdr_idx_ff + HdrIdxW'(1);
            end
         end
      end
   end

   // output register and skid register
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_rsp;
            out_valid_in = new_valid;
         end
      end else if (new_valid) begin
         if (out_valid_ff) begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = new_rsp;
            out_valid_in = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff    <= '0;
         flags_ff      <= '0;
         session_ff    <= '0;
         len_hi_ff     <= '0;
         remain_ff     <= '0;
         in_payload_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         hdr_idx_ff    <= hdr_idx_in;
         flags_ff      <= flags_in;
         session_ff    <= session_in;
         len_hi_ff     <= len_hi_in;
         remain_ff     <= remain_in;
         in_payload_ff <= in_payload_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_valid  = out_ff.payload_valid;
   assign rsp_push_bit       = out_ff.push_bit;
   assign rsp_control_kind   = out_ff.control_kind;
   assign rsp_session_id     = out_ff.session_id;
   assign rsp_last_of_packet = out_ff.last_of_packet;

   // skid register only fills behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while output register is empty");

   // header position stays at zero during payload
   a_hdr_idle_in_payload: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (hdr_idx_ff == '0))
      else $error("header position moved during payload");

   // last payload byte returns to header parsing
   a_last_ends_payload: assert property (@(posedge clock) disable iff (reset)
      (accept && in_payload_ff && remain_ff == 16'd1) |=> !in_payload_ff)
      else $error("payload did not end after last byte");

   // empty-packet marker is always the last beat
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.payload_valid) |-> out_ff.last_of_packet)
      else $error("empty packet marker without last flag");

endmodule

`default_nettype wire
